// ===== src/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// Types and constants shared by the max flow controller and datapath.
// ----------------------------------------------------------------------------
package mfb_pkg;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_SINK   = 1'b1;

  // Field widths fixed by the interface
  localparam int NODE_W = 4;
  localparam int CAPF_W = 16;
  localparam int FLOW_W = 20;
  localparam logic [FLOW_W-1:0] FLOW_MAX = '1;
  localparam logic [NODE_W-1:0] SOURCE_RST = 4'd0;
  localparam logic [NODE_W-1:0] SINK_RST   = 4'd15;

  // Controller states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN_CHK,
    ST_BFS_INIT,
    ST_DEQ,
    ST_DEQ_W,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_AUG1_START,
    ST_AUG1_P,
    ST_AUG1_PW,
    ST_AUG1_R,
    ST_AUG2_START,
    ST_AUG2_P,
    ST_AUG2_PW,
    ST_AUG2_F,
    ST_AUG2_R,
    ST_FLOW_ADD,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic cap_wr;
    logic run_start;
    logic bfs_init;
    logic deq_rd;
    logic deq_take;
    logic scan_rd;
    logic scan_ev;
    logic aug1_start;
    logic par_rd;
    logic par_take;
    logic aug1_min;
    logic aug2_start;
    logic aug2_fwd;
    logic aug2_rev;
    logic flow_add;
    logic out_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic run_ok;
    logic q_empty;
    logic head_is_dst;
    logic scan_last;
    logic v_is_src;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/max_flow_bfs_augment.sv =====
// ----------------------------------------------------------------------------
// max_flow_bfs_augment
// Edmonds-Karp maximum flow over a dense residual matrix held in a memory.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  in       | in_valid / in_stall | cmd, from_node, to_node, capacity
//  out      | out_valid/out_stall | flow_total
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  After reset a clearing pass zeroes all 2**(2*clog2(NODES)) matrix
//  entries (256 at default), one entry a cycle; no item is taken meanwhile.
//  A run repeats a search and an augmentation in a bottleneck pass and
//  an update pass, both bounded by the single matrix read port.
//  The result sits in an output register; a waiting result does not block
//  capacity writes, a second run waits for it at its end.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment
  import mfb_pkg::*;
#(
  parameter int NODES    = 16,
  parameter int CAP_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [CAPF_W-1:0] capacity,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FLOW_W-1:0] flow_total,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [NODE_W-1:0] cfg_data
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;

  // registers are always writable
  assign cfg_ready = 1'b1;

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .stat     (stat),
    .dcmd     (dcmd),
    .in_stall (in_stall)
  );

  mfb_datapath #(
    .NODES    (NODES),
    .CAP_BITS (CAP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dcmd       (dcmd),
    .stat       (stat),
    .from_node  (from_node),
    .to_node    (to_node),
    .capacity   (capacity),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .flow_total (flow_total)
  );

endmodule

// ===== src/mfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfb_ctrl
// Sequencer for the clearing pass, capacity writes, search and augmentation.
// ----------------------------------------------------------------------------
module mfb_ctrl
  import mfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     cmd,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd,
  output logic     in_stall
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    dcmd       = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        dcmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_RUN) state_next = ST_RUN_CHK;
          else dcmd.cap_wr = 1'b1;
        end
      end
      ST_RUN_CHK: begin
        dcmd.run_start = 1'b1;
        state_next = stat.run_ok ? ST_BFS_INIT : ST_DONE;
      end
      ST_BFS_INIT: begin
        dcmd.bfs_init = 1'b1;
        state_next = ST_DEQ;
      end
      ST_DEQ: begin
        if (stat.q_empty) begin
          state_next = ST_DONE;
        end else begin
          dcmd.deq_rd = 1'b1;
          state_next = ST_DEQ_W;
        end
      end
      ST_DEQ_W: begin
        if (stat.head_is_dst) begin
          state_next = ST_AUG1_START;
        end else begin
          dcmd.deq_take = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        dcmd.scan_rd = 1'b1;
        state_next = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        dcmd.scan_ev = 1'b1;
        state_next = stat.scan_last ? ST_DEQ : ST_SCAN_RD;
      end
      // bottleneck pass
      ST_AUG1_START: begin
        dcmd.aug1_start = 1'b1;
        state_next = ST_AUG1_P;
      end
      ST_AUG1_P: begin
        if (stat.v_is_src) begin
          state_next = ST_AUG2_START;
        end else begin
          dcmd.par_rd = 1'b1;
          state_next = ST_AUG1_PW;
        end
      end
      ST_AUG1_PW: begin
        dcmd.par_take = 1'b1;
        state_next = ST_AUG1_R;
      end
      ST_AUG1_R: begin
        dcmd.aug1_min = 1'b1;
        state_next = ST_AUG1_P;
      end
      // update pass
      ST_AUG2_START: begin
        dcmd.aug2_start = 1'b1;
        state_next = ST_AUG2_P;
      end
      ST_AUG2_P: begin
        if (stat.v_is_src) begin
          state_next = ST_FLOW_ADD;
        end else begin
          dcmd.par_rd = 1'b1;
          state_next = ST_AUG2_PW;
        end
      end
      ST_AUG2_PW: begin
        dcmd.par_take = 1'b1;
        state_next = ST_AUG2_F;
      end
      ST_AUG2_F: begin
        dcmd.aug2_fwd = 1'b1;
        state_next = ST_AUG2_R;
      end
      ST_AUG2_R: begin
        dcmd.aug2_rev = 1'b1;
        state_next = ST_AUG2_P;
      end
      ST_FLOW_ADD: begin
        dcmd.flow_add = 1'b1;
        state_next = ST_BFS_INIT;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          dcmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mfb_datapath.sv =====
// ----------------------------------------------------------------------------
// mfb_datapath
// Residual matrix, search queue, parent table and flow arithmetic.
// ----------------------------------------------------------------------------
module mfb_datapath
  import mfb_pkg::*;
#(
  parameter int NODES    = 16,
  parameter int CAP_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           dcmd,
  output dp_stat_t          stat,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  input  logic [CAPF_W-1:0] capacity,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [NODE_W-1:0] cfg_data,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [FLOW_W-1:0] flow_total
);

  localparam int NW    = $clog2(NODES);
  localparam int AW    = 2 * NW;
  localparam int RES_W = CAP_BITS + 8;
  localparam int SW    = ((RES_W > FLOW_W) ? RES_W : FLOW_W) + 1;

  logic [NODE_W-1:0] source_node, sink_node;
  logic [NW-1:0]     sidx, tidx, u, v;
  logic [NW:0]       head, tail;
  logic [NODES-1:0]  visited;
  logic [AW-1:0]     clr_cnt;
  logic [RES_W-1:0]  least, bneck;
  logic [FLOW_W-1:0] acc;
  logic [SW-1:0]     acc_sum;

  // memories
  logic [RES_W-1:0] res_mem [2**AW];
  logic [RES_W-1:0] res_rdata, res_wdata;
  logic [AW-1:0]    res_raddr, res_waddr;
  logic             res_we;
  logic [NW-1:0]    q_mem [2**NW];
  logic [NW-1:0]    q_rdata;
  logic             q_we;
  logic [NW-1:0]    q_wdata;
  logic [NW-1:0]    p_mem [2**NW];
  logic [NW-1:0]    p_rdata;
  logic             found;

  assign sidx = NW'(source_node);
  assign tidx = NW'(sink_node);
  assign found = (res_rdata != '0) && !visited[v];

  // status back to the controller
  always_comb begin
    stat.clr_last    = &clr_cnt;
    stat.run_ok      = (32'(source_node) < NODES) && (32'(sink_node) < NODES) &&
                       (source_node != sink_node);
    stat.q_empty     = (head == tail);
    stat.head_is_dst = (q_rdata == tidx);
    stat.scan_last   = (32'(v) == NODES - 1);
    stat.v_is_src    = (v == sidx);
    stat.out_free    = !out_valid || !out_stall;
  end

  // residual matrix port selection
  always_comb begin
    res_we    = 1'b0;
    res_waddr = {u, v};
    res_wdata = res_rdata - bneck;
    res_raddr = {u, v};
    if (dcmd.clr_step) begin
      res_we    = 1'b1;
      res_waddr = clr_cnt;
      res_wdata = '0;
    end else if (dcmd.cap_wr) begin
      res_we    = (32'(from_node) < NODES) && (32'(to_node) < NODES);
      res_waddr = {NW'(from_node), NW'(to_node)};
      res_wdata = RES_W'(CAP_BITS'(capacity));
    end else if (dcmd.aug2_fwd) begin
      res_we    = 1'b1;
      res_raddr = {v, u};
    end else if (dcmd.aug2_rev) begin
      res_we    = 1'b1;
      res_waddr = {v, u};
      res_wdata = res_rdata + bneck;
    end
    if (dcmd.par_take) res_raddr = {p_rdata, v};
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    res_rdata <= res_mem[res_raddr];
  end

  // search queue: written at tail, read at head
  assign q_we    = dcmd.bfs_init || (dcmd.scan_ev && found);
  assign q_wdata = dcmd.bfs_init ? sidx : v;

  always_ff @(posedge clk) begin
    if (q_we) q_mem[dcmd.bfs_init ? NW'(0) : tail[NW-1:0]] <= q_wdata;
    if (dcmd.deq_rd) q_rdata <= q_mem[head[NW-1:0]];
  end

  // parent table
  always_ff @(posedge clk) begin
    if (dcmd.scan_ev && found) p_mem[v] <= u;
    if (dcmd.par_rd) p_rdata <= p_mem[v];
  end

  assign acc_sum = SW'(acc) + SW'(bneck);

  // control and arithmetic registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt     <= '0;
      visited     <= '0;
      head        <= '0;
      tail        <= '0;
      acc         <= '0;
      bneck       <= '0;
      out_valid   <= 1'b0;
      source_node <= SOURCE_RST;
      sink_node   <= SINK_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SOURCE: source_node <= cfg_data;
          CFG_SINK:   sink_node   <= cfg_data;
          default:    source_node <= source_node;
        endcase
      end
      if (dcmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (dcmd.run_start) acc <= '0;
      if (dcmd.bfs_init) begin
        visited <= NODES'(1) << sidx;
        head <= '0;
        tail <= (NW+1)'(1);
      end
      if (dcmd.deq_rd) head <= head + 1'b1;
      if (dcmd.scan_ev && found) begin
        visited[v] <= 1'b1;
        tail <= tail + 1'b1;
      end
      if (dcmd.aug2_start) bneck <= least;
      if (dcmd.flow_add) begin
        acc <= (acc_sum > SW'(FLOW_MAX)) ? FLOW_MAX : acc_sum[FLOW_W-1:0];
      end
      // result register
      if (dcmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // node cursors, bottleneck and result payload
  always_ff @(posedge clk) begin
    if (dcmd.deq_take) begin
      u <= q_rdata;
      v <= '0;
    end
    if (dcmd.scan_ev) v <= v + 1'b1;
    if (dcmd.aug1_start || dcmd.aug2_start) v <= tidx;
    if (dcmd.aug1_start) least <= '1;
    if (dcmd.par_take) u <= p_rdata;
    if (dcmd.aug1_min) begin
      if (res_rdata < least) least <= res_rdata;
      v <= u;
    end
    if (dcmd.aug2_rev) v <= u;
    if (dcmd.out_load) flow_total <= acc;
  end

endmodule
